### rtl/minimum_spanning_tree_engine_core_assert.svh
// assertion macros used by the engine solver rtl
// all macros sample on clk_i and are disabled while rst_ni is low
`ifndef MINIMUM_SPANNING_TREE_ENGINE_CORE_ASSERT_SVH
`define MINIMUM_SPANNING_TREE_ENGINE_CORE_ASSERT_SVH

// same-cycle implication
`define MSTE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MSTE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/mste_pkg.sv
// ----------------------------------------------------------------------------
// mste_pkg
// shared types and constants of the spanning tree engine
// ----------------------------------------------------------------------------
`default_nettype none

package mste_pkg;

  localparam int MAX_VERTICES  = 64;
  localparam int VTX_W         = 6;
  localparam int WEIGHT_BITS   = 16;
  localparam int VCNT_W        = 7;
  localparam int TOT_W         = 22;
  localparam int RANK_W        = 3;
  localparam int DEF_MAX_EDGES = 256;
  localparam logic [VCNT_W-1:0] VCNT_RESET = VCNT_W'(MAX_VERTICES);

  localparam logic [1:0] ST_OK           = 2'd0;
  localparam logic [1:0] ST_DISCONNECTED = 2'd1;
  localparam logic [1:0] ST_OVERFLOW     = 2'd2;
  localparam logic [1:0] ST_RANGE        = 2'd3;

  typedef struct packed {
    logic [VTX_W-1:0]       src;
    logic [VTX_W-1:0]       dst;
    logic [WEIGHT_BITS-1:0] wt;
  } edge_t;

  // what the loader learned about one graph
  typedef struct packed {
    logic [1:0]       err;
    logic [VTX_W-1:0] maxv;
  } run_info_t;

endpackage

`default_nettype wire

### rtl/mste_edge_if.sv
// ----------------------------------------------------------------------------
// mste_edge_if
// edge input channel, valid/ready
// ----------------------------------------------------------------------------
`default_nettype none

interface mste_edge_if;
  import mste_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [VTX_W-1:0]       edge_source;
  logic [VTX_W-1:0]       edge_destination;
  logic [WEIGHT_BITS-1:0] edge_weight;
  logic                   last_edge;

  modport source (output valid, edge_source, edge_destination, edge_weight, last_edge,
                  input ready);
  modport sink   (input valid, edge_source, edge_destination, edge_weight, last_edge,
                  output ready);
endinterface

`default_nettype wire

### rtl/mste_tree_if.sv
// ----------------------------------------------------------------------------
// mste_tree_if
// result channel, tree edges then summary, valid/ready
// ----------------------------------------------------------------------------
`default_nettype none

interface mste_tree_if;
  import mste_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [VTX_W-1:0]       tree_source;
  logic [VTX_W-1:0]       tree_destination;
  logic [WEIGHT_BITS-1:0] tree_weight;
  logic                   is_summary;
  logic [TOT_W-1:0]       total_weight;
  logic [1:0]             status;
  logic                   last_result;

  modport source (output valid, tree_source, tree_destination, tree_weight, is_summary,
                  total_weight, status, last_result, input ready);
  modport sink   (input valid, tree_source, tree_destination, tree_weight, is_summary,
                  total_weight, status, last_result, output ready);
endinterface

`default_nettype wire

### rtl/mste_cmd_fifo.sv
// ----------------------------------------------------------------------------
// mste_cmd_fifo
// two-entry queue of run commands between loader and solver
// ----------------------------------------------------------------------------
`default_nettype none

module mste_cmd_fifo #(
  parameter int W = 8
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire logic [W-1:0] data_i,
  output logic              full_o,
  input  wire logic         pop_i,
  output logic              empty_o,
  output logic [W-1:0]      data_o
);

  logic [W-1:0] mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i && !full_o) wp_q <= ~wp_q;
      if (pop_i && !empty_o) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'((push_i && !full_o) ? 1 : 0) - 2'((pop_i && !empty_o) ? 1 : 0);
    end
  end

endmodule

`default_nettype wire

### rtl/mste_front.sv
// ----------------------------------------------------------------------------
// mste_front
// edge loader: stores edges, tracks overflow and largest vertex, queues runs
// ----------------------------------------------------------------------------
`default_nettype none

module mste_front #(
  parameter int MAX_EDGES = 256,
  parameter int CW = $clog2(MAX_EDGES + 1),
  parameter int EW = $clog2(MAX_EDGES)
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  mste_edge_if.sink            edge_i,
  output logic                 ewe_o,
  output logic [EW-1:0]        ewaddr_o,
  output mste_pkg::edge_t      ewdata_o,
  output logic                 push_o,
  output logic [CW-1:0]        cmd_cnt_o,
  output mste_pkg::run_info_t  cmd_info_o,
  input  wire logic            full_i,
  input  wire logic            done_i
);
  import mste_pkg::*;

  logic [CW-1:0]    cnt_q, cnt_d;
  logic [1:0]       err_q, err_d;
  logic [VTX_W-1:0] maxv_q, maxv_d;
  logic             busy_q;
  logic             xfer, room;
  logic [VTX_W-1:0] hi;

  assign edge_i.ready = !busy_q && !full_i;
  assign xfer = edge_i.valid && edge_i.ready;
  assign room = (cnt_q < CW'(MAX_EDGES));
  assign hi   = (edge_i.edge_source > edge_i.edge_destination) ?
                edge_i.edge_source : edge_i.edge_destination;

  assign ewe_o         = xfer && room;
  assign ewaddr_o      = cnt_q[EW-1:0];
  assign ewdata_o.src  = edge_i.edge_source;
  assign ewdata_o.dst  = edge_i.edge_destination;
  assign ewdata_o.wt   = edge_i.edge_weight;

  always_comb begin
    cnt_d  = cnt_q;
    err_d  = err_q;
    maxv_d = maxv_q;
    if (xfer) begin
      if (room) begin
        cnt_d = cnt_q + CW'(1);
        if (hi > maxv_q) maxv_d = hi;
      end else if (err_q == ST_OK) begin
        err_d = ST_OVERFLOW;
      end
    end
  end

  assign push_o          = xfer && edge_i.last_edge;
  assign cmd_cnt_o       = cnt_d;
  assign cmd_info_o.err  = err_d;
  assign cmd_info_o.maxv = maxv_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      err_q  <= ST_OK;
      maxv_q <= '0;
      busy_q <= 1'b0;
    end else begin
      if (push_o) begin
        // graph handed over, start the next one clean
        cnt_q  <= '0;
        err_q  <= ST_OK;
        maxv_q <= '0;
        busy_q <= 1'b1;
      end else begin
        cnt_q  <= cnt_d;
        err_q  <= err_d;
        maxv_q <= maxv_d;
        if (done_i) busy_q <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/mste_back.sv
// ----------------------------------------------------------------------------
// mste_back
// solver: edge memory, ordered scan, union-find sequencer, result register
// ----------------------------------------------------------------------------
`default_nettype none
`include "minimum_spanning_tree_engine_core_assert.svh"

module mste_back #(
  parameter int MAX_EDGES = 256,
  parameter int CW = $clog2(MAX_EDGES + 1),
  parameter int EW = $clog2(MAX_EDGES)
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        ewe_i,
  input  wire logic [EW-1:0]               ewaddr_i,
  input  wire mste_pkg::edge_t             ewdata_i,
  input  wire logic                        empty_i,
  input  wire logic [CW-1:0]               cmd_cnt_i,
  input  wire mste_pkg::run_info_t         cmd_info_i,
  output logic                             pop_o,
  output logic                             done_o,
  input  wire logic [mste_pkg::VCNT_W-1:0] vcount_i,
  mste_tree_if.source                      tree_o
);
  import mste_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_INIT  = 4'd2;
  localparam logic [3:0] S_SCAN  = 4'd3;
  localparam logic [3:0] S_FIND  = 4'd4;
  localparam logic [3:0] S_CMP   = 4'd5;
  localparam logic [3:0] S_RKA   = 4'd6;
  localparam logic [3:0] S_RKB   = 4'd7;
  localparam logic [3:0] S_JOIN  = 4'd8;
  localparam logic [3:0] S_SUM   = 4'd9;
  localparam logic [VCNT_W-1:0] NMAX = VCNT_W'(MAX_VERTICES);

  // memories
  edge_t             emem [MAX_EDGES];
  edge_t             erd_q;
  logic [EW-1:0]     eraddr;
  logic [VTX_W-1:0]  pmem [MAX_VERTICES];
  logic [VTX_W-1:0]  prd_q, praddr, pwaddr, pwdata;
  logic              pwe;
  logic [RANK_W-1:0] rmem [MAX_VERTICES];
  logic [RANK_W-1:0] rrd_q, rwdata;
  logic [VTX_W-1:0]  rraddr, rwaddr;
  logic              rwe;

  // sequencer
  logic [3:0]             state_q, state_d;
  logic [CW-1:0]          cnt_q, j_q, j_d;
  logic [1:0]             err_q;
  logic [VTX_W-1:0]       maxv_q, i_q;
  logic [VCNT_W-1:0]      n_q, acc_q, n_in;
  logic                   pv_q, pv_d;
  logic [EW-1:0]          pidx_q;
  logic                   hl_q, hb_q, hb_d;
  logic [WEIGHT_BITS-1:0] lw_q, bw_q, bw_d;
  logic [EW-1:0]          li_q, bi_q, bi_d;
  logic [VTX_W-1:0]       bs_q, bs_d, bd_q, bd_d;
  logic [VTX_W-1:0]       cur_q, root_q, ra_q, rka_pad, start;
  logic [RANK_W-1:0]      rka_q;
  logic                   sel_q;
  logic [TOT_W-1:0]       tot_q;
  logic [1:0]             sum_st_q, sum_st_d;
  logic                   issue, cand, take, scan_end, free, found, walked;

  // output register
  logic                   ov_q;
  logic [VTX_W-1:0]       os_q, od_q;
  logic [WEIGHT_BITS-1:0] ow_q;
  logic                   osum_q;
  logic [TOT_W-1:0]       otot_q;
  logic [1:0]             ost_q;
  logic                   ld_edge, ld_sum;

  assign free = !ov_q || tree_o.ready;

  assign n_in = (vcount_i == '0) ? VCNT_W'(1) : ((vcount_i > NMAX) ? NMAX : vcount_i);

  // ordered scan: next edge after (lw, li) in (weight, arrival) order
  assign issue    = (j_q < cnt_q);
  assign cand     = pv_q && (!hl_q || erd_q.wt > lw_q ||
                             (erd_q.wt == lw_q && pidx_q > li_q));
  assign take     = cand && (!hb_q || erd_q.wt < bw_q);
  assign scan_end = !issue && !pv_q;
  assign eraddr   = j_q[EW-1:0];

  assign start   = sel_q ? bd_q : bs_q;
  assign found   = (prd_q == cur_q);
  assign walked  = (prd_q == root_q);
  assign rka_pad = ra_q;

  always_comb begin
    state_d  = state_q;
    j_d      = j_q;
    pv_d     = 1'b0;
    hb_d     = hb_q;
    bw_d     = bw_q;
    bi_d     = bi_q;
    bs_d     = bs_q;
    bd_d     = bd_q;
    sum_st_d = sum_st_q;
    praddr   = cur_q;
    pwe      = 1'b0;
    pwaddr   = cur_q;
    pwdata   = root_q;
    rraddr   = root_q;
    rwe      = 1'b0;
    rwaddr   = i_q;
    rwdata   = '0;
    ld_edge  = 1'b0;
    ld_sum   = 1'b0;
    pop_o    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (err_q != ST_OK) begin
          sum_st_d = err_q;
          state_d  = S_SUM;
        end else if ({1'b0, maxv_q} >= n_q) begin
          sum_st_d = ST_RANGE;
          state_d  = S_SUM;
        end else begin
          state_d = S_INIT;
        end
      end
      S_INIT: begin
        pwe    = 1'b1;
        pwaddr = i_q;
        pwdata = i_q;
        rwe    = 1'b1;
        if (i_q == VTX_W'(MAX_VERTICES - 1)) begin
          j_d  = '0;
          hb_d = 1'b0;
          if (n_q <= VCNT_W'(1)) begin
            sum_st_d = ST_OK;
            state_d  = S_SUM;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (issue) begin
          j_d  = j_q + CW'(1);
          pv_d = 1'b1;
        end
        if (take) begin
          hb_d = 1'b1;
          bw_d = erd_q.wt;
          bi_d = pidx_q;
          bs_d = erd_q.src;
          bd_d = erd_q.dst;
        end
        if (scan_end) begin
          if (hb_q) begin
            praddr  = bs_q;
            state_d = S_FIND;
          end else begin
            sum_st_d = ST_DISCONNECTED;
            state_d  = S_SUM;
          end
        end
      end
      S_FIND: begin
        if (found) begin
          praddr  = start;
          state_d = S_CMP;
        end else begin
          praddr = prd_q;
        end
      end
      S_CMP: begin
        if (walked || cur_q == root_q) begin
          if (!sel_q) begin
            praddr  = bd_q;
            state_d = S_FIND;
          end else if (ra_q != root_q) begin
            state_d = S_RKA;
          end else begin
            j_d     = '0;
            hb_d    = 1'b0;
            state_d = S_SCAN;
          end
        end else begin
          // path compression: point this node straight at the root
          pwe    = 1'b1;
          praddr = prd_q;
        end
      end
      S_RKA: begin
        rraddr  = rka_pad;
        state_d = S_RKB;
      end
      S_RKB: begin
        state_d = S_JOIN;
      end
      S_JOIN: begin
        if (free) begin
          ld_edge = 1'b1;
          pwe     = 1'b1;
          if (rka_q < rrd_q) begin
            pwaddr = ra_q;
            pwdata = root_q;
          end else begin
            pwaddr = root_q;
            pwdata = ra_q;
            if (rka_q == rrd_q) begin
              rwe    = 1'b1;
              rwaddr = ra_q;
              rwdata = rka_q + RANK_W'(1);
            end
          end
          j_d  = '0;
          hb_d = 1'b0;
          if ({1'b0, acc_q} + 8'd2 >= {1'b0, n_q}) begin
            sum_st_d = ST_OK;
            state_d  = S_SUM;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SUM: begin
        if (free) begin
          ld_sum  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign done_o = ld_sum;

  // memories
  always_ff @(posedge clk_i) begin
    if (ewe_i) emem[ewaddr_i] <= ewdata_i;
    erd_q <= emem[eraddr];
  end

  always_ff @(posedge clk_i) begin
    if (pwe) pmem[pwaddr] <= pwdata;
    prd_q <= pmem[praddr];
  end

  always_ff @(posedge clk_i) begin
    if (rwe) rmem[rwaddr] <= rwdata;
    rrd_q <= rmem[rraddr];
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pidx_q <= eraddr;
    bw_q   <= bw_d;
    bi_q   <= bi_d;
    bs_q   <= bs_d;
    bd_q   <= bd_d;
    sum_st_q <= sum_st_d;
    if (state_q == S_IDLE && !empty_i) begin
      cnt_q  <= cmd_cnt_i;
      err_q  <= cmd_info_i.err;
      maxv_q <= cmd_info_i.maxv;
      n_q    <= n_in;
    end
    if (state_q == S_RKB) rka_q <= rrd_q;
    if (ld_edge) begin
      os_q   <= bs_q;
      od_q   <= bd_q;
      ow_q   <= bw_q;
      osum_q <= 1'b0;
      otot_q <= '0;
      ost_q  <= ST_OK;
    end else if (ld_sum) begin
      os_q   <= '0;
      od_q   <= '0;
      ow_q   <= '0;
      osum_q <= 1'b1;
      otot_q <= tot_q;
      ost_q  <= sum_st_q;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      j_q     <= '0;
      pv_q    <= 1'b0;
      hb_q    <= 1'b0;
      hl_q    <= 1'b0;
      lw_q    <= '0;
      li_q    <= '0;
      i_q     <= '0;
      cur_q   <= '0;
      sel_q   <= 1'b0;
      root_q  <= '0;
      ra_q    <= '0;
      acc_q   <= '0;
      tot_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      j_q     <= j_d;
      pv_q    <= pv_d;
      hb_q    <= hb_d;
      if (state_q == S_IDLE) begin
        hl_q  <= 1'b0;
        i_q   <= '0;
        acc_q <= '0;
        tot_q <= '0;
      end
      if (state_q == S_INIT) i_q <= i_q + VTX_W'(1);
      if (state_q == S_SCAN && scan_end && hb_q) begin
        // this edge is the next in order
        hl_q  <= 1'b1;
        lw_q  <= bw_q;
        li_q  <= bi_q;
        cur_q <= bs_q;
        sel_q <= 1'b0;
      end
      if (state_q == S_FIND) begin
        if (found) begin
          root_q <= cur_q;
          if (!sel_q) ra_q <= cur_q;
          cur_q <= start;
        end else begin
          cur_q <= prd_q;
        end
      end
      if (state_q == S_CMP) begin
        if (walked || cur_q == root_q) begin
          if (!sel_q) begin
            sel_q <= 1'b1;
            cur_q <= bd_q;
          end
        end else begin
          cur_q <= prd_q;
        end
      end
      if (ld_edge) begin
        acc_q <= acc_q + VCNT_W'(1);
        tot_q <= tot_q + TOT_W'(bw_q);
      end
      if (ld_edge || ld_sum) ov_q <= 1'b1;
      else if (tree_o.ready)  ov_q <= 1'b0;
    end
  end

  assign tree_o.valid            = ov_q;
  assign tree_o.tree_source      = os_q;
  assign tree_o.tree_destination = od_q;
  assign tree_o.tree_weight      = ow_q;
  assign tree_o.is_summary       = osum_q;
  assign tree_o.total_weight     = otot_q;
  assign tree_o.status           = ost_q;
  assign tree_o.last_result      = osum_q;

  `MSTE_ASSERT_NOW(a_join_distinct, state_q == S_JOIN, ra_q != root_q, "join of one root")
  `MSTE_ASSERT_NOW(a_scan_bound, state_q == S_SCAN, j_q <= cnt_q, "scan past edge count")
  `MSTE_ASSERT_NEXT(a_acc_bound, ld_edge, acc_q < n_q, "more tree edges than vertices")

endmodule

`default_nettype wire

### rtl/minimum_spanning_tree_engine_core.sv
// loading: one edge transfer per cycle while edge ready is high; the run starts after the last edge
// run: union-find init over all MAX_VERTICES entries, then per edge taken in order one ordered
//   scan of the stored edges plus find walks
// the edge memory read port sets the scan rate; results leave through one output register
// reset clears all control state at once; no clearing pass, the union-find stores are
//   rewritten at the start of each run
// ----------------------------------------------------------------------------
// minimum_spanning_tree_engine_core
// kruskal spanning tree engine with union-find, loader and solver decoupled
// by a command queue
// ----------------------------------------------------------------------------
`default_nettype none

module minimum_spanning_tree_engine_core #(
  parameter int MAX_EDGES = mste_pkg::DEF_MAX_EDGES
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [mste_pkg::VCNT_W-1:0] cfg_data_i,
  mste_edge_if.sink                        edge_i,
  mste_tree_if.source                      tree_o
);
  import mste_pkg::*;

  localparam int CW = $clog2(MAX_EDGES + 1);
  localparam int EW = $clog2(MAX_EDGES);
  localparam int QW = CW + $bits(run_info_t);

  // vertex count register; the user must write it only while idle, the block does not enforce this
  logic [VCNT_W-1:0] vcount_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= VCNT_RESET;
    end else if (cfg_we_i) begin
      vcount_q <= cfg_data_i;
    end
  end

  // loader to solver: edge writes go straight to the edge memory
  logic          ewe;
  logic [EW-1:0] ewaddr;
  edge_t         ewdata;

  // run command queue
  logic          push, full, pop, empty, done;
  logic [CW-1:0] cmd_cnt, q_cnt;
  run_info_t     cmd_info, q_info;
  logic [QW-1:0] q_out;

  mste_front #(
    .MAX_EDGES(MAX_EDGES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .edge_i     (edge_i),
    .ewe_o      (ewe),
    .ewaddr_o   (ewaddr),
    .ewdata_o   (ewdata),
    .push_o     (push),
    .cmd_cnt_o  (cmd_cnt),
    .cmd_info_o (cmd_info),
    .full_i     (full),
    .done_i     (done)
  );

  mste_cmd_fifo #(
    .W(QW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  ({cmd_cnt, cmd_info}),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (q_out)
  );

  assign q_cnt  = q_out[QW-1 -: CW];
  assign q_info = q_out[$bits(run_info_t)-1:0];

  // solver: ordered scan plus union-find, owns the output register
  mste_back #(
    .MAX_EDGES(MAX_EDGES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ewe_i      (ewe),
    .ewaddr_i   (ewaddr),
    .ewdata_i   (ewdata),
    .empty_i    (empty),
    .cmd_cnt_i  (q_cnt),
    .cmd_info_i (q_info),
    .pop_o      (pop),
    .done_o     (done),
    .vcount_i   (vcount_q),
    .tree_o     (tree_o)
  );

endmodule

`default_nettype wire

### sim/minimum_spanning_tree_engine_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// minimum_spanning_tree_engine_core_test
// self-checking bench for the spanning tree engine: drives edge graphs over
// the valid/ready channel, predicts tree edges and summaries in a scoreboard
// and compares every result transfer field by field
// ----------------------------------------------------------------------------
module minimum_spanning_tree_engine_core_test;
  import mste_pkg::*;

  localparam int STORE_DEPTH = DEF_MAX_EDGES;
  localparam int IDLE_LIMIT  = 200000;

  typedef struct packed {
    logic [VTX_W-1:0]       src;
    logic [VTX_W-1:0]       dst;
    logic [WEIGHT_BITS-1:0] wt;
    logic                   summ;
    logic [TOT_W-1:0]       total;
    logic [1:0]             status;
    logic                   last;
  } tree_result_t;

  // predicts tree edges and summaries from the accepted edge transfers
  class mst_scoreboard;
    edge_t             graph_edges[$];
    logic [1:0]        load_err;
    logic [VCNT_W-1:0] vcount;
    tree_result_t      expected_q[$];
    int                errors;
    int                parent[MAX_VERTICES];
    int                rnk[MAX_VERTICES];

    function new();
      load_err = ST_OK;
      vcount   = VCNT_RESET;
      errors   = 0;
    endfunction

    function void set_vertex_count(logic [VCNT_W-1:0] v);
      vcount = v;
    endfunction

    function int find_root(int v);
      int r, nxt;
      r = v;
      while (parent[r] != r) r = parent[r];
      while (parent[v] != r) begin
        nxt = parent[v];
        parent[v] = r;
        v = nxt;
      end
      return r;
    endfunction

    function void note_edge(edge_t e, logic last);
      int n, accepted, j, ra, rb;
      logic [1:0] st;
      logic [TOT_W-1:0] total;
      int order[$];
      tree_result_t r;
      if (graph_edges.size() < STORE_DEPTH) graph_edges.push_back(e);
      else if (load_err == ST_OK) load_err = ST_OVERFLOW;
      if (!last) return;
      n = (vcount == 0) ? 1 : (vcount > MAX_VERTICES) ? MAX_VERTICES : vcount;
      st = load_err;
      total = '0;
      if (st == ST_OK)
        foreach (graph_edges[i])
          if (graph_edges[i].src >= n || graph_edges[i].dst >= n) st = ST_RANGE;
      if (st == ST_OK) begin
        // stable insertion by weight keeps ties in arrival order
        foreach (graph_edges[i]) begin
          j = order.size();
          while (j > 0 && graph_edges[order[j-1]].wt > graph_edges[i].wt) j--;
          order.insert(j, i);
        end
        for (int v = 0; v < MAX_VERTICES; v++) begin
          parent[v] = v;
          rnk[v] = 0;
        end
        accepted = 0;
        for (int i = 0; i < order.size() && accepted + 1 < n; i++) begin
          ra = find_root(graph_edges[order[i]].src);
          rb = find_root(graph_edges[order[i]].dst);
          if (ra != rb) begin
            r = '0;
            r.src = graph_edges[order[i]].src;
            r.dst = graph_edges[order[i]].dst;
            r.wt  = graph_edges[order[i]].wt;
            expected_q.push_back(r);
            total += graph_edges[order[i]].wt;
            if (rnk[ra] < rnk[rb]) parent[ra] = rb;
            else if (rnk[ra] > rnk[rb]) parent[rb] = ra;
            else begin
              parent[rb] = ra;
              rnk[ra] = (rnk[ra] + 1) & 7;
            end
            accepted++;
          end
        end
        if (accepted + 1 < n) st = ST_DISCONNECTED;
      end
      r = '0;
      r.summ   = 1'b1;
      r.total  = total;
      r.status = st;
      r.last   = 1'b1;
      expected_q.push_back(r);
      graph_edges.delete();
      load_err = ST_OK;
    endfunction

    function void check_result(tree_result_t got);
      tree_result_t exp;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
        return;
      end
      exp = expected_q.pop_front();
      if (got.src !== exp.src)
        $display("%0t: tree_source exp %0d got %0d", $time, exp.src, got.src);
      if (got.dst !== exp.dst)
        $display("%0t: tree_destination exp %0d got %0d", $time, exp.dst, got.dst);
      if (got.wt !== exp.wt)
        $display("%0t: tree_weight exp %0d got %0d", $time, exp.wt, got.wt);
      if (got.summ !== exp.summ)
        $display("%0t: is_summary exp %0d got %0d", $time, exp.summ, got.summ);
      if (got.total !== exp.total)
        $display("%0t: total_weight exp %0d got %0d", $time, exp.total, got.total);
      if (got.status !== exp.status)
        $display("%0t: status exp %0d got %0d", $time, exp.status, got.status);
      if (got.last !== exp.last)
        $display("%0t: last_result exp %0d got %0d", $time, exp.last, got.last);
      if (got !== exp) errors++;
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [VCNT_W-1:0] cfg_data_i;

  mste_edge_if edge_bus ();
  mste_tree_if tree_bus ();

  minimum_spanning_tree_engine_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .edge_i     (edge_bus),
    .tree_o     (tree_bus)
  );

  mst_scoreboard sb = new();
  bit quiet;       // no idling in the closing part of the run
  bit long_hold;   // receiver holds off for a long stretch
  int sent_edges;
  int idle_cycles;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // result side: ready bursts driven at the falling edge
  initial begin
    tree_bus.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold) begin
        tree_bus.ready <= 1'b0;
        repeat (399) @(negedge clk_i);
        long_hold = 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        tree_bus.ready <= 1'b0;
        repeat ($urandom_range(0, 13)) @(negedge clk_i);
      end else begin
        tree_bus.ready <= 1'b1;
      end
    end
  end

  // check every result transfer; watchdog on cycles with no transfer at all
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (tree_bus.valid && tree_bus.ready)
        sb.check_result({tree_bus.tree_source, tree_bus.tree_destination,
                         tree_bus.tree_weight, tree_bus.is_summary,
                         tree_bus.total_weight, tree_bus.status, tree_bus.last_result});
      if ((tree_bus.valid && tree_bus.ready) || (edge_bus.valid && edge_bus.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // one edge transfer, with an optional gap before it
  task automatic send_edge(int s, int d, int w, bit last);
    edge_t e;
    e.src = s;
    e.dst = d;
    e.wt  = w;
    @(negedge clk_i);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      edge_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
    end
    edge_bus.valid            <= 1'b1;
    edge_bus.edge_source      <= e.src;
    edge_bus.edge_destination <= e.dst;
    edge_bus.edge_weight      <= e.wt;
    edge_bus.last_edge        <= last;
    @(posedge clk_i);
    while (!edge_bus.ready) @(posedge clk_i);
    sb.note_edge(e, last);
    sent_edges++;
  endtask

  // drop valid and wait until every result is in, then let the block settle
  task automatic drain();
    @(negedge clk_i);
    edge_bus.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  // register write, only ever called once the block is idle
  task automatic write_vertex_count(int v);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_vertex_count(v);
  endtask

  // random graph over n vertices: mostly a random spanning tree plus extras
  task automatic send_graph(int n, int kind);
    edge_t g[$];
    edge_t e;
    int extra, wmax;
    wmax = ($urandom_range(0, 1) == 0) ? 15 : 65535;
    if (kind == 0) begin
      // noise: endpoints anywhere, usually out of range
      repeat ($urandom_range(1, 6)) begin
        e.src = $urandom;
        e.dst = $urandom;
        e.wt  = $urandom;
        g.push_back(e);
      end
    end else begin
      if (kind != 1)
        for (int v = 1; v < n; v++) begin
          e.src = v;
          e.dst = $urandom_range(0, v - 1);
          e.wt  = $urandom_range(0, wmax);
          g.push_back(e);
        end
      extra = $urandom_range(1, 5);
      repeat (extra) begin
        e.src = $urandom_range(0, n - 1);
        e.dst = $urandom_range(0, n - 1);
        e.wt  = $urandom_range(0, wmax);
        g.push_back(e);
      end
      g.shuffle();
    end
    foreach (g[i]) begin
      if ($urandom_range(0, 1)) send_edge(g[i].dst, g[i].src, g[i].wt, i == g.size() - 1);
      else send_edge(g[i].src, g[i].dst, g[i].wt, i == g.size() - 1);
    end
  endtask

  initial begin
    int n, graphs;
    rst_ni                    = 1'b0;
    cfg_we_i                  = 1'b0;
    cfg_data_i                = '0;
    edge_bus.valid            = 1'b0;
    edge_bus.edge_source      = '0;
    edge_bus.edge_destination = '0;
    edge_bus.edge_weight      = '0;
    edge_bus.last_edge        = 1'b0;
    quiet      = 1'b0;
    long_hold  = 1'b0;
    sent_edges = 0;
    idle_cycles = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset value of the register: full range, corner vertices, disconnected
    send_edge(63, 0, 1, 0);
    send_edge(0, 63, 2, 1);
    drain();
    // single vertex with a self loop
    write_vertex_count(1);
    send_edge(0, 0, 0, 1);
    drain();
    // zero vertex count behaves as one
    write_vertex_count(0);
    send_edge(0, 0, 65535, 1);
    drain();
    // weight extremes, ties in arrival order, self loop
    write_vertex_count(4);
    send_edge(0, 1, 65535, 0);
    send_edge(1, 2, 0, 0);
    send_edge(2, 3, 5, 0);
    send_edge(3, 0, 5, 0);
    send_edge(1, 1, 3, 1);
    // two components
    send_edge(0, 1, 7, 0);
    send_edge(2, 3, 7, 1);
    drain();
    // vertex count above the maximum saturates
    write_vertex_count(127);
    send_edge(62, 63, 65535, 1);
    drain();
    // endpoint out of range
    write_vertex_count(3);
    send_edge(0, 3, 1, 1);
    drain();
    write_vertex_count(2);
    send_edge(0, 1, 9, 1);
    drain();

    // edge store overflow, then a clean graph right after
    write_vertex_count(64);
    for (int i = 0; i < STORE_DEPTH + 2; i++)
      send_edge($urandom_range(0, 63), $urandom_range(0, 63), $urandom, i == STORE_DEPTH + 1);
    send_graph(64, 2);
    drain();

    // receiver holds off while graphs keep coming
    write_vertex_count(6);
    long_hold = 1'b1;
    repeat (5) send_graph(6, 2);
    drain();

    // random phases, one register setting each
    while (sent_edges < 410) begin
      if (sent_edges > 350) quiet = 1'b1;
      n = ($urandom_range(0, 9) == 0) ? 64 : $urandom_range(2, 10);
      write_vertex_count(n);
      graphs = (n == 64) ? 1 : $urandom_range(1, 4);
      repeat (graphs) begin
        case ($urandom_range(0, 9))
          0:       send_graph(n, 0);
          1:       send_graph(n, 1);
          default: send_graph(n, 2);
        endcase
      end
      drain();
    end

    repeat (100) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
